>>> design/cni_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cni_pkg
// Shared types and constants for the curve node interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package cni_pkg;

  localparam int MaxNodes = 32;
  localparam int IdxW = $clog2(MaxNodes);
  localparam int CntW = $clog2(MaxNodes + 1);
  localparam int CfgW = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgSettle = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBetween = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOutside = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StEarly = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SHIFT, S_SHIFT_WAIT, S_INSERT,
    S_RD_A, S_RD_B, S_RD_WAIT, S_MUL, S_DIV, S_FINISH, S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic rd_scan;
    logic scan_step;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic ovr_wr;
    logic cnt_inc;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic mul;
    logic div_start;
    logic div_step;
    logic set_res_lin;
    logic set_res_val;
    logic [1:0] status;
    logic res_zero;
    logic out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic scan_done;
    logic exact;
    logic empty;
    logic full;
    logic early;
    logic single;
    logic at_end;
    logic at_start;
    logic shift_done;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> design/cni_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cni_in_if / cni_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface cni_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [15:0] day_number;
  logic signed [31:0] node_value;
  modport source (output valid, opcode, day_number, node_value, input ready);
  modport sink (input valid, opcode, day_number, node_value, output ready);
endinterface

interface cni_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] curve_value;
  logic [1:0] status;
  logic saturated;
  modport source (output valid, curve_value, status, saturated, input ready);
  modport sink (input valid, curve_value, status, saturated, output ready);
endinterface
`default_nettype wire

>>> design/cni_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cni_ctrl
// Sequencer for table search, insert shift and interpolation division.
// ----------------------------------------------------------------------------
`default_nettype none
module cni_ctrl
  import cni_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  out_free_i,
  input  wire logic  between_i,
  input  wire logic  outside_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_item = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end else begin
          ctrl_o.rd_scan = 1'b1;
          state_d = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        ctrl_o.scan_step = 1'b1;
        state_d = S_SCAN;
      end
      S_DECIDE: begin
        if (!stat_i.is_query) begin
          if (stat_i.exact) begin
            ctrl_o.ovr_wr = 1'b1;
            ctrl_o.res_zero = 1'b1;
            ctrl_o.status = StOk;
            state_d = S_OUT;
          end else if (stat_i.full) begin
            ctrl_o.res_zero = 1'b1;
            ctrl_o.status = StFull;
            state_d = S_OUT;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (stat_i.empty) begin
          ctrl_o.res_zero = 1'b1;
          ctrl_o.status = StEmpty;
          state_d = S_OUT;
        end else if (stat_i.early) begin
          ctrl_o.res_zero = 1'b1;
          ctrl_o.status = StEarly;
          state_d = S_OUT;
        end else begin
          ctrl_o.status = StOk;
          ctrl_o.rd_a = 1'b1;
          state_d = S_RD_A;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = S_INSERT;
        end else begin
          ctrl_o.shift_rd = 1'b1;
          state_d = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: begin
        ctrl_o.shift_wr = 1'b1;
        state_d = S_SHIFT;
      end
      S_INSERT: begin
        ctrl_o.ins_wr = 1'b1;
        ctrl_o.cnt_inc = 1'b1;
        ctrl_o.res_zero = 1'b1;
        ctrl_o.status = StOk;
        state_d = S_OUT;
      end
      S_RD_A: begin
        ctrl_o.cap_a = 1'b1;
        ctrl_o.rd_b = 1'b1;
        state_d = S_RD_B;
      end
      S_RD_B: begin
        ctrl_o.cap_b = 1'b1;
        state_d = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        // choose between stored value and linear result
        if (stat_i.single || (stat_i.exact && !stat_i.at_end)) begin
          ctrl_o.set_res_val = 1'b1;
          state_d = S_OUT;
        end else if ((stat_i.at_end || stat_i.at_start) ? outside_i : between_i) begin
          ctrl_o.mul = 1'b1;
          state_d = S_MUL;
        end else begin
          ctrl_o.set_res_val = 1'b1;
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        ctrl_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_FINISH;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        ctrl_o.set_res_lin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/cni_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cni_datapath
// Node memories, search index, multiplier and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module cni_datapath
  import cni_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_t              ctrl_i,
  output stat_t                   stat_o,
  input  wire logic               opcode_i,
  input  wire logic [15:0]        day_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [15:0]        settle_i,
  output logic signed [31:0]      res_o,
  output logic [1:0]              status_o,
  output logic                    sat_o
);

  localparam int ProdW = 50;  // 17 x 33 signed
  localparam int DivCntW = 6;

  logic [15:0] day_mem [MaxNodes];
  logic [31:0] val_mem [MaxNodes];

  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] sh_q;
  logic            op_q;
  logic [15:0]     day_q;
  logic [31:0]     wval_q;
  logic [15:0]     rd_day_q;
  logic [31:0]     rd_val_q;
  logic            found_q;
  logic            exact_q;
  logic [15:0]     da_q, db_q;
  logic signed [31:0] va_q, vb_q;
  logic signed [ProdW-1:0] prod_q;
  logic [ProdW-1:0] rem_q;
  logic [ProdW-1:0] quo_q;
  logic [16:0]     den_q;
  logic            neg_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [1:0]      status_q;
  logic signed [31:0] res_q;
  logic            sat_q;

  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] a_idx, b_idx;

  // pair selection for the query
  always_comb begin
    if (idx_q >= cnt_q) begin
      a_idx = cnt_q - CntW'(2);
      b_idx = cnt_q - CntW'(1);
    end else if (idx_q == '0) begin
      a_idx = '0;
      b_idx = CntW'(1);
    end else begin
      a_idx = idx_q - CntW'(1);
      b_idx = idx_q;
    end
  end

  // memory read address
  always_comb begin
    rd_addr = idx_q[IdxW-1:0];
    if (ctrl_i.shift_rd) begin
      rd_addr = IdxW'(sh_q - CntW'(1));
    end else if (ctrl_i.rd_a) begin
      rd_addr = a_idx[IdxW-1:0];
    end else if (ctrl_i.rd_b) begin
      rd_addr = b_idx[IdxW-1:0];
    end
  end

  // node memories
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_scan || ctrl_i.shift_rd || ctrl_i.rd_a || ctrl_i.rd_b) begin
      rd_day_q <= day_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
    if (ctrl_i.shift_wr) begin
      day_mem[sh_q[IdxW-1:0]] <= rd_day_q;
      val_mem[sh_q[IdxW-1:0]] <= rd_val_q;
    end else if (ctrl_i.ins_wr) begin
      day_mem[idx_q[IdxW-1:0]] <= day_q;
      val_mem[idx_q[IdxW-1:0]] <= wval_q;
    end else if (ctrl_i.ovr_wr) begin
      val_mem[idx_q[IdxW-1:0]] <= wval_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      sh_q <= '0;
      found_q <= 1'b0;
      exact_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (ctrl_i.load_item) begin
        idx_q <= '0;
        sh_q <= cnt_q;
        found_q <= 1'b0;
        exact_q <= 1'b0;
      end else if (ctrl_i.scan_step) begin
        if (rd_day_q >= day_q) begin
          found_q <= 1'b1;
          exact_q <= (rd_day_q == day_q);
        end else begin
          idx_q <= idx_q + CntW'(1);
        end
      end else if (ctrl_i.shift_wr) begin
        sh_q <= sh_q - CntW'(1);
      end
      if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (ctrl_i.div_start) begin
        dcnt_q <= DivCntW'(ProdW);
      end else if (ctrl_i.div_step) begin
        dcnt_q <= dcnt_q - DivCntW'(1);
      end
    end
  end

  logic [16:0]       tmin;
  logic signed [32:0] vdiff;
  logic [ProdW:0]    trial;
  logic [ProdW-1:0]  rem_sh;
  logic signed [33:0] lin;
  logic [ProdW-1:0]  qr;

  assign tmin = {1'b0, day_q} - {1'b0, da_q};
  assign vdiff = 33'(vb_q) - 33'(va_q);
  assign rem_sh = {rem_q[ProdW-2:0], quo_q[ProdW-1]};
  assign trial = {1'b0, rem_sh} - (ProdW + 1)'(den_q);

  // quotient rounding: half the divisor added up front
  always_comb begin
    qr = quo_q;
    if (neg_q) begin
      lin = 34'(va_q) - 34'(signed'({1'b0, qr}));
    end else begin
      lin = 34'(va_q) + 34'(signed'({1'b0, qr}));
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      op_q <= opcode_i;
      day_q <= day_i;
      wval_q <= value_i;
    end
    if (ctrl_i.cap_a) begin
      da_q <= rd_day_q;
      va_q <= rd_val_q;
    end
    if (ctrl_i.cap_b) begin
      db_q <= rd_day_q;
      vb_q <= rd_val_q;
    end
    if (ctrl_i.mul) begin
      prod_q <= ProdW'(signed'(tmin) * vdiff);
      den_q <= {1'b0, db_q} - {1'b0, da_q};
    end
    if (ctrl_i.div_start) begin
      neg_q <= prod_q[ProdW-1];
      rem_q <= '0;
      quo_q <= (prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q))
               + ProdW'(den_q[16:1]);
    end else if (ctrl_i.div_step) begin
      if (!trial[ProdW]) begin
        rem_q <= trial[ProdW-1:0];
        quo_q <= {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[ProdW-2:0], 1'b0};
      end
    end
    if (ctrl_i.res_zero) begin
      res_q <= '0;
      sat_q <= 1'b0;
    end else if (ctrl_i.set_res_val) begin
      // first node sits in the a slot, every other answer in the b slot
      res_q <= (idx_q == '0) ? va_q : vb_q;
      sat_q <= 1'b0;
    end else if (ctrl_i.set_res_lin) begin
      // a quotient of 2^32 or more is out of range whatever the base value
      if (|quo_q[ProdW-1:32] || (lin > 34'sh07fffffff)) begin
        res_q <= neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
        sat_q <= 1'b1;
      end else if (lin < -34'sh080000000) begin
        res_q <= 32'h8000_0000;
        sat_q <= 1'b1;
      end else begin
        res_q <= lin[31:0];
        sat_q <= 1'b0;
      end
    end
    if (ctrl_i.res_zero || ctrl_i.rd_a) begin
      status_q <= ctrl_i.status;
    end
  end

  // status back to the controller
  always_comb begin
    stat_o = '0;
    stat_o.is_query = (op_q == OpQuery);
    stat_o.scan_done = found_q || (idx_q >= cnt_q);
    stat_o.exact = exact_q;
    stat_o.empty = (cnt_q == '0);
    stat_o.full = (cnt_q >= CntW'(MaxNodes));
    stat_o.early = (day_q < settle_i);
    stat_o.single = (cnt_q == CntW'(1));
    stat_o.at_end = (idx_q >= cnt_q);
    stat_o.at_start = (idx_q == '0) && !exact_q;
    stat_o.shift_done = (sh_q <= idx_q);
    stat_o.div_done = (dcnt_q == '0);
  end

  assign res_o = res_q;
  assign status_o = status_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

>>> design/curve_node_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curve_node_interpolator_top
// Sorted curve node table with step/linear interpolation and extrapolation.
// ----------------------------------------------------------------------------
// operation: a write runs the search loop and, for a new day, the shift loop
//   through the single-port node memory; a linear query runs the search loop
//   and then the 50-step restoring divider
// throughput: one item at a time; the next item is taken once the result
//   is in the output register
// reset: node count and control/config registers cleared; memory and data undefined
`default_nettype none
module curve_node_interpolator_top
  import cni_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  cni_in_if.sink                  in_if,
  cni_out_if.source               out_if,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic [15:0] settle_q;
  logic        between_q;
  logic        outside_q;
  logic        ovalid_q;
  logic signed [31:0] oval_q;
  logic [1:0]  ostat_q;
  logic        osat_q;
  ctrl_t       ctrl;
  stat_t       stat;
  logic        in_ready;
  logic signed [31:0] res;
  logic [1:0]  res_status;
  logic        res_sat;
  logic        out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
      between_q <= 1'b0;
      outside_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSettle:  settle_q <= cfg_data_i;
        CfgBetween: between_q <= cfg_data_i[0];
        CfgOutside: outside_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free = !ovalid_q || out_if.ready;
  assign in_if.ready = in_ready;

  cni_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .between_i  (between_q),
    .outside_i  (outside_q),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cni_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .opcode_i (in_if.opcode),
    .day_i    (in_if.day_number),
    .value_i  (in_if.node_value),
    .settle_i (settle_q),
    .res_o    (res),
    .status_o (res_status),
    .sat_o    (res_sat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      oval_q <= res;
      ostat_q <= res_status;
      osat_q <= res_sat;
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.curve_value = oval_q;
  assign out_if.status = ostat_q;
  assign out_if.saturated = osat_q;

endmodule
`default_nettype wire

>>> test/tb_curve_node_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_curve_node_interpolator_top
// Drives node writes and curve queries through the valid/ready channels,
// predicts each result with a behavioral copy of the node table unless one is
// typed in, and compares status, value and saturation flag field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_curve_node_interpolator_top
  import cni_pkg::*;
();

  localparam int NodeCap = MaxNodes;
  localparam longint CycleLimit = 2_000_000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0] status;
    logic sat;
  } answer_t;

  typedef struct {
    logic op;
    logic [15:0] day;
    logic signed [31:0] val;
    logic known;
    answer_t ans;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgSettle;
  logic [CfgW-1:0] cfg_data_i = '0;

  cni_in_if in_ch();
  cni_out_if out_ch();

  curve_node_interpolator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [15:0] settle_day;
  logic lin_between;
  logic lin_outside;
  logic [15:0] tbl_day [NodeCap];
  logic signed [31:0] tbl_val [NodeCap];
  int tbl_cnt;

  answer_t pending_answers[$];
  int errors = 0;
  int sender_idle = 26;
  int receiver_idle = 67;
  bit hold_off = 1'b0;
  longint cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // exact linear point with round half away from zero and saturation
  function automatic answer_t line_point(int a, int b, logic [15:0] t);
    answer_t r;
    longint da, db, va, vb, num, den, mag, q, res;
    da = tbl_day[a]; db = tbl_day[b]; va = tbl_val[a]; vb = tbl_val[b];
    den = db - da;
    num = (longint'(t) - da) * (vb - va);
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    res = (num < 0) ? va - q : va + q;
    r.status = StOk;
    r.sat = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647; r.sat = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648; r.sat = 1'b1;
    end
    r.value = res[31:0];
    return r;
  endfunction

  // apply one transaction to the node table and return its answer
  function automatic answer_t curve_answer(logic op, logic [15:0] day, logic signed [31:0] v);
    answer_t r;
    int i;
    r = '{value: '0, status: StOk, sat: 1'b0};
    i = 0;
    while (i < tbl_cnt && tbl_day[i] < day) i++;
    if (op == OpWrite) begin
      if (i < tbl_cnt && tbl_day[i] == day) tbl_val[i] = v;
      else if (tbl_cnt >= NodeCap) r.status = StFull;
      else begin
        for (int k = tbl_cnt; k > i; k--) begin
          tbl_day[k] = tbl_day[k-1]; tbl_val[k] = tbl_val[k-1];
        end
        tbl_day[i] = day; tbl_val[i] = v; tbl_cnt++;
      end
    end else if (tbl_cnt == 0) r.status = StEmpty;
    else if (day < settle_day) r.status = StEarly;
    else if (tbl_cnt == 1) r.value = tbl_val[0];
    else if (i >= tbl_cnt) begin
      if (lin_outside) r = line_point(tbl_cnt - 2, tbl_cnt - 1, day);
      else r.value = tbl_val[tbl_cnt-1];
    end else if (tbl_day[i] == day) r.value = tbl_val[i];
    else if (i == 0) begin
      if (lin_outside) r = line_point(0, 1, day);
      else r.value = tbl_val[0];
    end else begin
      if (lin_between) r = line_point(i - 1, i, day);
      else r.value = tbl_val[i];
    end
    return r;
  endfunction

  // receiver side, also the checker
  initial begin
    answer_t got, want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{value: out_ch.curve_value, status: out_ch.status, sat: out_ch.saturated};
        if (pending_answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp value %0d st %0d sat %0d, got value %0d st %0d sat %0d",
                       want.value, want.status, want.sat, got.value, got.status, got.sat);
          end
        end
      end
      @(negedge clk_i);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= receiver_idle);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSettle:  settle_day = data;
      CfgBetween: lin_between = data[0];
      CfgOutside: lin_outside = data[0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // one transaction on the input channel, checked against the table when
  // no answer is typed in
  task automatic send_item(vec_t v);
    answer_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle) @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= v.op; in_ch.day_number <= v.day; in_ch.node_value <= v.val;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = curve_answer(v.op, v.day, v.val);
    pending_answers.insert(pending_answers.size(), v.known ? v.ans : pred);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  function automatic vec_t mk(logic op, logic [15:0] d, logic signed [31:0] v);
    vec_t r;
    r.op = op; r.day = d; r.val = v; r.known = 1'b0; r.ans = '0;
    return r;
  endfunction

  function automatic vec_t mk_exp(logic op, logic [15:0] d, logic signed [31:0] v,
                                  logic signed [31:0] ev, logic [1:0] st);
    vec_t r;
    r = mk(op, d, v);
    r.known = 1'b1; r.ans = '{value: ev, status: st, sat: 1'b0};
    return r;
  endfunction

  // random item, days drawn from the full range, both ends and the existing nodes
  task automatic random_item();
    logic op;
    logic [15:0] d;
    logic signed [31:0] v;
    op = ($urandom_range(99) < 60) ? OpQuery : OpWrite;
    case ($urandom_range(3))
      0: d = 16'($urandom());
      1: d = 16'($urandom_range(200));
      2: d = (tbl_cnt > 0) ? tbl_day[$urandom_range(tbl_cnt - 1)] : 16'd0;
      default: d = 16'hFFFF - 16'($urandom_range(200));
    endcase
    case ($urandom_range(3))
      0: v = $urandom();
      1: v = $signed($urandom_range(2000)) - 1000;
      2: v = ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: v = $signed(32'($urandom_range(32'h0FFF_FFFF))) - 32'sh0800_0000;
    endcase
    send_item(mk(op, d, v));
  endtask

  initial begin
    vec_t steps[$];
    in_ch.valid = 1'b0; in_ch.opcode = OpWrite;
    in_ch.day_number = '0; in_ch.node_value = '0;
    settle_day = '0; lin_between = 1'b0; lin_outside = 1'b0; tbl_cnt = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table: empty, extremes, exact, hold, step, overwrite
    steps = {steps, mk_exp(OpQuery, 16'd100, 32'sd0, 32'sd0, StEmpty)};
    steps = {steps, mk_exp(OpWrite, 16'd100, 32'sh7FFFFFFF, 32'sd0, StOk)};
    steps = {steps, mk_exp(OpQuery, 16'd0, 32'sd0, 32'sh7FFFFFFF, StOk)};
    steps = {steps, mk_exp(OpWrite, 16'd0, 32'sh80000000, 32'sd0, StOk)};
    steps = {steps, mk_exp(OpWrite, 16'hFFFF, 32'sh0100_0000, 32'sd0, StOk)};
    steps = {steps, mk_exp(OpQuery, 16'd0, 32'sd0, 32'sh80000000, StOk)};
    steps = {steps, mk_exp(OpQuery, 16'd50, 32'sd0, 32'sh7FFFFFFF, StOk)};
    steps = {steps, mk_exp(OpQuery, 16'hFFFF, 32'sd0, 32'sh0100_0000, StOk)};
    steps = {steps, mk_exp(OpWrite, 16'd100, -32'sd5, 32'sd0, StOk)};
    steps = {steps, mk(OpQuery, 16'd100, 32'sd0)};
    steps = {steps, mk(OpQuery, 16'd1000, 32'hFFFF_FFFF)};
    foreach (steps[k]) send_item(steps[k]);
    drain_results();

    // linear between and outside, including saturation, then settlement
    write_reg(CfgBetween, 16'd1);
    write_reg(CfgOutside, 16'd1);
    steps.delete();
    steps = {steps, mk(OpQuery, 16'd50, 32'sd0)};
    steps = {steps, mk(OpQuery, 16'd30000, 32'sd0)};
    steps = {steps, mk(OpWrite, 16'd200, 32'sh7FFFFFFF)};
    steps = {steps, mk(OpWrite, 16'd10, 32'sh80000000)};
    steps = {steps, mk(OpWrite, 16'd0, 32'sh7FFFFFFF)};
    steps = {steps, mk(OpQuery, 16'd5, 32'sd0)};
    steps = {steps, mk(OpQuery, 16'd7, 32'sd0)};
    foreach (steps[k]) send_item(steps[k]);
    drain_results();
    write_reg(CfgSettle, 16'hFFFF);
    send_item(mk_exp(OpQuery, 16'hFFFE, 32'sd0, 32'sd0, StEarly));
    send_item(mk(OpQuery, 16'hFFFF, 32'sd0));
    drain_results();
    write_reg(CfgSettle, 16'd0);

    // fill the table to capacity, then a full-table write
    for (int k = 0; tbl_cnt < NodeCap; k++)
      send_item(mk(OpWrite, 16'(300 + 7 * k), $urandom()));
    send_item(mk_exp(OpWrite, 16'd299, 32'sd1, 32'sd0, StFull));
    send_item(mk(OpQuery, 16'd303, 32'sd0));
    drain_results();

    // back pressure: receiver stalls while the sender keeps offering items
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (6) random_item();
    join
    drain_results();

    // random phases over several register settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin sender_idle = 67; receiver_idle = 26; end
      if (ph == 4) begin sender_idle = 0; receiver_idle = 0; end
      write_reg(CfgSettle, (ph == 5) ? 16'hFFFF : ((ph % 2) ? 16'($urandom_range(300)) : 16'd0));
      write_reg(CfgBetween, 16'(ph % 2));
      write_reg(CfgOutside, 16'((ph / 2) % 2));
      // random traffic against the full table: overwrites, full writes, queries
      repeat (132) random_item();
      drain_results();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
